/* rtl/pab_pkg.sv */
// Package for the premultiplied alpha blender: shared types, constants
// and the rounded divide by 255. No dependencies.
`default_nettype none

package pab_pkg;

    localparam int          LANES          = 4;
    localparam int          COLOR_LANES    = 3;
    localparam logic [7:0]  OPACITY_RESET  = 8'hFF;
    localparam logic [7:0]  OPAQUE_ALPHA   = 8'hFF;
    localparam logic [16:0] ROUND_BIAS     = 17'h00080;
    localparam logic [15:0] FULL_WEIGHT    = 16'd255;

    // Scaled source and destination between the scale and mix halves.
    typedef struct packed {
        logic [31:0] src_scaled;
        logic [31:0] dst;
    } pab_scaled_t;

    // (v + (v >> 8) + 0x80) >> 8, low 8 bits kept
    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [16:0] t;
        t = {1'b0, v} + {9'b0, v[15:8]} + ROUND_BIAS;
        return t[15:8];
    endfunction

endpackage

`default_nettype wire

/* rtl/pab_pixel_if.sv */
// Input channel of the blender: source and destination pixel per word.
// No dependencies.
`default_nettype none

interface pab_pixel_if;
    logic        valid;
    logic        ready;
    logic [31:0] src_pixel;
    logic [31:0] dst_pixel;

    modport source (output valid, output src_pixel, output dst_pixel, input ready);
    modport sink   (input valid, input src_pixel, input dst_pixel, output ready);
endinterface

`default_nettype wire

/* rtl/pab_result_if.sv */
// Output channel of the blender: one composited pixel per word.
// No dependencies.
`default_nettype none

interface pab_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_pixel;

    modport source (output valid, output out_pixel, input ready);
    modport sink   (input valid, input out_pixel, output ready);
endinterface

`default_nettype wire

/* rtl/pab_cfg_if.sv */
// Configuration write channel of the blender: the opacity byte.
// No dependencies.
`default_nettype none

interface pab_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] opacity;

    modport source (output valid, output opacity, input ready);
    modport sink   (input valid, input opacity, output ready);
endinterface

`default_nettype wire

/* rtl/pab_scale.sv */
// Opacity scaling, two stages: lane multiply, then rounded divide by 255.
// Depends on pab_pkg.
`default_nettype none

module pab_scale
    import pab_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [7:0]  opacity,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] src_pixel,
    input  wire logic [31:0] dst_pixel,
    output logic             out_valid,
    input  wire logic        out_ready,
    output pab_scaled_t      out_word
);

    logic        v1_reg;
    logic [15:0] prod_reg [LANES];
    logic [15:0] prod_next [LANES];
    logic [31:0] src1_reg;
    logic [31:0] dst1_reg;
    logic        pass1_reg;

    logic        v2_reg;
    pab_scaled_t word2_reg;
    pab_scaled_t word2_next;

    logic        ready1;
    logic        ready2;

    assign ready2   = !v2_reg || out_ready;
    assign ready1   = !v1_reg || ready2;
    assign in_ready = ready1;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            prod_next[i] = {8'h00, src_pixel[8*i +: 8]} * {8'h00, opacity};
        end
    end

    always_comb
    begin
        word2_next.dst = dst1_reg;
        if (pass1_reg)
        begin
            word2_next.src_scaled = src1_reg;
        end
        else
        begin
            for (int i = 0; i < LANES; i++)
            begin
                word2_next.src_scaled[8*i +: 8] = div255(prod_reg[i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                v1_reg <= in_valid;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1 && in_valid)
        begin
            prod_reg  <= prod_next;
            src1_reg  <= src_pixel;
            dst1_reg  <= dst_pixel;
            pass1_reg <= (opacity == OPACITY_RESET);
        end
        if (ready2 && v1_reg)
        begin
            word2_reg <= word2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_word  = word2_reg;

endmodule

`default_nettype wire

/* rtl/pab_mix.sv */
// Over compositing, two stages: weighted channel sums, then divide by 255.
// Depends on pab_pkg.
`default_nettype none

module pab_mix
    import pab_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire pab_scaled_t in_word,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      out_pixel
);

    logic        v3_reg;
    logic [15:0] sum_reg  [COLOR_LANES];
    logic [15:0] sum_next [COLOR_LANES];
    logic [31:0] s3_reg;
    logic        opaque3_reg;

    logic        v4_reg;
    logic [31:0] pix4_reg;
    logic [31:0] pix4_next;

    logic        ready3;
    logic        ready4;
    logic [7:0]  inv_alpha;

    assign ready4    = !v4_reg || out_ready;
    assign ready3    = !v3_reg || ready4;
    assign in_ready  = ready3;
    assign inv_alpha = OPAQUE_ALPHA - in_word.src_scaled[31:24];

    // sums wrap to 16 bits
    always_comb
    begin
        for (int i = 0; i < COLOR_LANES; i++)
        begin
            sum_next[i] = ({8'h00, in_word.src_scaled[8*i +: 8]} * FULL_WEIGHT)
                        + ({8'h00, in_word.dst[8*i +: 8]} * {8'h00, inv_alpha});
        end
    end

    always_comb
    begin
        pix4_next = {OPAQUE_ALPHA, 24'h000000};
        if (opaque3_reg)
        begin
            pix4_next = s3_reg;
        end
        else
        begin
            for (int i = 0; i < COLOR_LANES; i++)
            begin
                pix4_next[8*i +: 8] = div255(sum_reg[i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (ready3)
            begin
                v3_reg <= in_valid;
            end
            if (ready4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready3 && in_valid)
        begin
            sum_reg     <= sum_next;
            s3_reg      <= in_word.src_scaled;
            opaque3_reg <= (in_word.src_scaled[31:24] == OPAQUE_ALPHA);
        end
        if (ready4 && v3_reg)
        begin
            pix4_reg <= pix4_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_pixel = pix4_reg;

endmodule

`default_nettype wire

/* rtl/premultiplied_alpha_blend.sv */
// Throughput: one pixel per clock; four register stages (multiply, divide,
// blend sums, divide) each hold a word and stall independently.
// Reset (rst_n, async, active low) empties all stages, opacity becomes 255.
// Top level of the premultiplied ARGB8888 over blender.
// Depends on pab_pkg, the pab_*_if interfaces, pab_scale and pab_mix.
`default_nettype none

module premultiplied_alpha_blend
    import pab_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    pab_cfg_if.sink       cfg,
    pab_pixel_if.sink     pixels,
    pab_result_if.source  result
);

    logic [7:0]  opacity_reg;
    logic        mid_valid;
    logic        mid_ready;
    pab_scaled_t mid_word;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opacity_reg <= OPACITY_RESET;
        end
        else if (cfg.valid)
        begin
            opacity_reg <= cfg.opacity;
        end
    end

    pab_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .opacity   (opacity_reg),
        .in_valid  (pixels.valid),
        .in_ready  (pixels.ready),
        .src_pixel (pixels.src_pixel),
        .dst_pixel (pixels.dst_pixel),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .out_word  (mid_word)
    );

    pab_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .in_word   (mid_word),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_pixel (result.out_pixel)
    );

endmodule

`default_nettype wire

/* rtl/pab_checker.sv */
// Port-level assertions for the blender and the bind that attaches them.
// Depends on premultiplied_alpha_blend.
`default_nettype none

module pab_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        cfg_ready,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] out_pixel
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_pixel))
        else $error("stalled result word changed or dropped");

    // every result is opaque
    a_out_opaque: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_pixel[31:24] == 8'hFF)
        else $error("result alpha not opaque");

    // empty output stage means the whole pipe can move
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while output stage empty");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config channel not ready");

    // a word accepted into a free-flowing pipe reaches the output stage
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && out_ready ##1 out_ready ##1 out_ready ##1 out_ready
        |=> out_valid)
        else $error("result word missing after four cycles");

endmodule

bind premultiplied_alpha_blend pab_checker u_pab_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_ready (cfg.ready),
    .in_valid  (pixels.valid),
    .in_ready  (pixels.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_pixel (result.out_pixel)
);

`default_nettype wire

/* bench/tb_premultiplied_alpha_blend.sv */
`timescale 1ns / 1ps
// Self-checking bench for premultiplied_alpha_blend: drives source/destination
// words under several opacity settings and checks each composited pixel.
// Depends on pab_pkg, the pab_*_if interfaces and the RTL top level.

module tb_premultiplied_alpha_blend;
    import pab_pkg::*;

    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASES       = 8;
    localparam int PHASE_WORDS  = 200;

    class blend_scoreboard;
        logic [7:0]  opacity;
        logic [31:0] blended_q[$];
        int          checked;
        int          errors;

        function new();
            opacity = OPACITY_RESET;
            checked = 0;
            errors  = 0;
        endfunction

        function void set_opacity(input logic [7:0] op);
            opacity = op;
        endfunction

        function logic [7:0] div255_round(input logic [15:0] v);
            logic [31:0] t;
            t = {16'd0, v} + {24'd0, v[15:8]} + 32'h80;
            return t[15:8];
        endfunction

        function logic [31:0] blend_over(input logic [31:0] src, input logic [31:0] dst);
            logic [31:0] s;
            logic [31:0] res;
            logic [31:0] sum;
            logic [15:0] prod;
            logic [7:0]  inv;
            s = src;
            if (opacity != OPACITY_RESET)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    prod = {8'd0, src[i*8 +: 8]} * {8'd0, opacity};
                    s[i*8 +: 8] = div255_round(prod);
                end
            end
            if (s[31:24] == OPAQUE_ALPHA)
                return s;
            inv = OPAQUE_ALPHA - s[31:24];
            res = {OPAQUE_ALPHA, 24'd0};
            // channel sums wrap at 16 bits when the source is not premultiplied
            for (int i = 0; i < 3; i++)
            begin
                sum = {24'd0, s[i*8 +: 8]} * 32'd255 + {24'd0, dst[i*8 +: 8]} * {24'd0, inv};
                res[i*8 +: 8] = div255_round(sum[15:0]);
            end
            return res;
        endfunction

        function void note_pixel(input logic [31:0] src, input logic [31:0] dst);
            blended_q.push_back(blend_over(src, dst));
        endfunction

        function void check_result(input logic [31:0] got);
            logic [31:0] want;
            if (blended_q.size() == 0)
            begin
                errors++;
                $display("%0t: out_pixel %08h with no word expected", $time, got);
                return;
            end
            want = blended_q.pop_front();
            checked++;
            if (got !== want)
            begin
                errors++;
                $display("%0t: out_pixel expected %08h actual %08h", $time, want, got);
            end
        endfunction

        function int pending();
            return blended_q.size();
        endfunction

        function void finish_check();
            if (blended_q.size() != 0)
            begin
                errors += blended_q.size();
                $display("%0t: %0d words never arrived, next expected %08h",
                         $time, blended_q.size(), blended_q[0]);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   calm;
    int   idle_cycles = 0;
    int   settings = 0;
    blend_scoreboard sb;

    pab_cfg_if    cfg_ch ();
    pab_pixel_if  pix_ch ();
    pab_result_if res_ch ();

    premultiplied_alpha_blend DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .pixels (pix_ch),
        .result (res_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // mostly premultiplied sources, some opaque or clear, a quarter raw noise
    function automatic logic [31:0] random_src();
        logic [7:0] a;
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 25)
            return $urandom();
        if (kind < 40)
            a = OPAQUE_ALPHA;
        else if (kind < 50)
            a = 8'h00;
        else
            a = 8'($urandom_range(0, 255));
        return {a, 8'($urandom_range(0, a)), 8'($urandom_range(0, a)),
                8'($urandom_range(0, a))};
    endfunction

    task automatic send_pixel(input logic [31:0] src, input logic [31:0] dst);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_ch.valid     <= 1'b1;
        pix_ch.src_pixel <= src;
        pix_ch.dst_pixel <= dst;
        do @(posedge clk); while (!pix_ch.ready);
    endtask

    task automatic drain();
        pix_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_opacity(input logic [7:0] op);
        drain();
        cfg_ch.valid   <= 1'b1;
        cfg_ch.opacity <= op;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
        settings++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                sb.set_opacity(cfg_ch.opacity);
            if (pix_ch.valid && pix_ch.ready)
                sb.note_pixel(pix_ch.src_pixel, pix_ch.dst_pixel);
            if (res_ch.valid && res_ch.ready)
                sb.check_result(res_ch.out_pixel);
            if ((cfg_ch.valid && cfg_ch.ready) || (pix_ch.valid && pix_ch.ready)
                || (res_ch.valid && res_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : result_sink
        int hold;
        hold = 0;
        res_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                res_ch.ready <= 1'b0;
                hold--;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    hold = idle_gap();
            end
        end
    end

    initial
    begin : watchdog
        wait (rst_n === 1'b1);
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : stimulus
        logic [7:0] op;
        sb = new();
        calm = 1'b0;
        rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.opacity = OPACITY_RESET;
        pix_ch.valid = 1'b0;
        pix_ch.src_pixel = 32'd0;
        pix_ch.dst_pixel = 32'd0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset opacity: pass-through scaling
        send_pixel(32'h0000_0000, 32'hFFFF_FFFF);
        send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
        send_pixel(32'hFF12_3456, 32'h00AB_CDEF);
        send_pixel(32'h8040_4040, 32'h00FF_8000);
        send_pixel(32'h10FF_FFFF, 32'hFFFF_FFFF);
        send_pixel(32'h00FF_FFFF, 32'hFFFF_FFFF);
        send_pixel(32'hFE7F_7F7F, 32'h1234_5678);
        send_pixel(32'h0101_0101, 32'hFFFF_FFFF);

        write_opacity(8'h80);
        send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
        send_pixel(32'hFF80_4020, 32'hFFFF_FFFF);
        send_pixel(32'h10FF_FFFF, 32'h8080_8080);
        send_pixel(32'h7F7F_7F7F, 32'h00FF_00FF);

        write_opacity(8'h00);
        send_pixel(32'hFFFF_FFFF, 32'h1234_5678);
        send_pixel(32'h0000_0000, 32'hFFFF_FFFF);

        write_opacity(8'hFE);
        send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
        send_pixel(32'hFFFF_0000, 32'h0000_FF00);
        send_pixel(32'h00FF_FFFF, 32'hFFFF_FFFF);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: op = 8'hFF;
                1: op = 8'h00;
                2: op = 8'h01;
                3: op = 8'hFE;
                4: op = 8'h80;
                default: op = 8'($urandom_range(0, 255));
            endcase
            write_opacity(op);
            calm = (phase == 3);
            for (int n = 0; n < PHASE_WORDS; n++)
                send_pixel(random_src(), $urandom());
        end

        drain();
        sb.finish_check();
        $display("checked %0d composited pixels across %0d opacity writes", sb.checked, settings);
        $display("opacity 0, 1, 128, 254, 255 and random values, %0d mismatches", sb.errors);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* files.f */
rtl/pab_pkg.sv
rtl/pab_pixel_if.sv
rtl/pab_result_if.sv
rtl/pab_cfg_if.sv
rtl/pab_scale.sv
rtl/pab_mix.sv
rtl/premultiplied_alpha_blend.sv
rtl/pab_checker.sv
bench/tb_premultiplied_alpha_blend.sv
